// File: sv/rltd_pkg.sv
package rltd_pkg;

    localparam int CNT_W       = 7;
    localparam int FLEN_W      = 3;
    localparam int SYM_LEN     = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0]  CNT_SAT  = 7'd127;
    localparam logic [FLEN_W-1:0] FLEN_MAX = 3'd7;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE = 8'h27;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_SYMBOL     = 2'd0,
        KIND_BAD_COUNT  = 2'd1,
        KIND_BAD_SYMBOL = 2'd2,
        KIND_END        = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CP_BLANK  = 2'd0,
        CP_SIGN   = 2'd1,
        CP_DIGITS = 2'd2,
        CP_DONE   = 2'd3
    } t_count_phase;

    // One command for the expansion side: emit sym cnt times.
    typedef struct packed {
        logic [7:0]       sym;
        t_kind            kind;
        logic [CNT_W-1:0] cnt;
        logic             msg_end;
    } t_cmd;

endpackage

// File: sv/rltd_front.sv
module rltd_front #(
    parameter int MAX_RUN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  logic [7:0]         i_text_byte,
    input  logic               i_end_of_text,
    output logic               o_cmd_vld,
    output rltd_pkg::t_cmd     o_cmd
);

    localparam logic [rltd_pkg::CNT_W-1:0] MAX_RUN_C = rltd_pkg::CNT_W'(MAX_RUN);

    rltd_pkg::t_count_phase        r_phase, n_phase;
    logic                          r_exp_sym, n_exp_sym;
    logic [rltd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_neg, n_neg;
    logic [rltd_pkg::FLEN_W-1:0]   r_flen, n_flen;
    logic                          r_drop, n_drop;
    logic [7:0]                    r_sym [rltd_pkg::SYM_LEN];
    logic [7:0]                    n_sym [rltd_pkg::SYM_LEN];

    logic        comma;
    logic        digit;
    logic        blank;
    logic [3:0]  dig_val;
    logic [10:0] acc_val;
    logic        sym_ok;

    assign comma   = (i_text_byte == rltd_pkg::CHAR_COMMA);
    assign digit   = (i_text_byte >= rltd_pkg::CHAR_ZERO) && (i_text_byte <= rltd_pkg::CHAR_NINE);
    assign blank   = (i_text_byte == rltd_pkg::CHAR_SPACE) ||
                     ((i_text_byte >= rltd_pkg::CHAR_TAB) && (i_text_byte <= rltd_pkg::CHAR_CR));
    assign dig_val = 4'(i_text_byte - rltd_pkg::CHAR_ZERO);
    assign acc_val = ({4'b0, r_cnt} << 3) + ({4'b0, r_cnt} << 1) + {7'b0, dig_val};

    always_comb begin
        n_phase   = r_phase;
        n_exp_sym = r_exp_sym;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_flen    = r_flen;
        n_drop    = r_drop;
        for (int i = 0; i < rltd_pkg::SYM_LEN; i++) begin
            n_sym[i] = r_sym[i];
        end
        o_cmd_vld     = 1'b0;
        o_cmd.sym     = 8'd0;
        o_cmd.kind    = rltd_pkg::KIND_END;
        o_cmd.cnt     = rltd_pkg::CNT_W'(1);
        o_cmd.msg_end = 1'b0;
        sym_ok        = 1'b0;

        if (i_acc) begin
            if (!r_drop) begin
                // Fold the byte into the open field.
                if (!comma) begin
                    if (r_exp_sym) begin
                        if (r_flen < rltd_pkg::FLEN_W'(rltd_pkg::SYM_LEN)) begin
                            n_sym[r_flen[1:0]] = i_text_byte;
                        end
                        if (r_flen < rltd_pkg::FLEN_MAX) begin
                            n_flen = r_flen + 1'b1;
                        end
                    end else begin
                        case (r_phase)
                            rltd_pkg::CP_BLANK: begin
                                if (blank) begin
                                    n_phase = rltd_pkg::CP_BLANK;
                                end else if (i_text_byte == rltd_pkg::CHAR_PLUS) begin
                                    n_phase = rltd_pkg::CP_SIGN;
                                end else if (i_text_byte == rltd_pkg::CHAR_MINUS) begin
                                    n_neg   = 1'b1;
                                    n_phase = rltd_pkg::CP_SIGN;
                                end else if (digit) begin
                                    n_cnt   = {3'b0, dig_val};
                                    n_phase = rltd_pkg::CP_DIGITS;
                                end else begin
                                    n_phase = rltd_pkg::CP_DONE;
                                end
                            end
                            rltd_pkg::CP_SIGN: begin
                                if (digit) begin
                                    n_cnt   = {3'b0, dig_val};
                                    n_phase = rltd_pkg::CP_DIGITS;
                                end else begin
                                    n_phase = rltd_pkg::CP_DONE;
                                end
                            end
                            rltd_pkg::CP_DIGITS: begin
                                if (digit) begin
                                    n_cnt = (acc_val > 11'(rltd_pkg::CNT_SAT)) ?
                                            rltd_pkg::CNT_SAT : acc_val[rltd_pkg::CNT_W-1:0];
                                end else begin
                                    n_phase = rltd_pkg::CP_DONE;
                                end
                            end
                            default: begin
                                n_phase = rltd_pkg::CP_DONE;
                            end
                        endcase
                    end
                end

                // Close the field on a comma or on the final byte.
                if (comma || i_end_of_text) begin
                    if (!r_exp_sym) begin
                        n_phase = rltd_pkg::CP_BLANK;
                        if ((n_cnt == '0) || (!n_neg && (n_cnt > MAX_RUN_C))) begin
                            o_cmd_vld  = 1'b1;
                            o_cmd.kind = rltd_pkg::KIND_BAD_COUNT;
                            n_drop     = 1'b1;
                        end else begin
                            n_exp_sym = 1'b1;
                        end
                    end else begin
                        sym_ok = (n_flen == rltd_pkg::FLEN_W'(rltd_pkg::SYM_LEN)) &&
                                 (n_sym[0] == rltd_pkg::CHAR_QUOTE) &&
                                 (n_sym[2] == rltd_pkg::CHAR_QUOTE);
                        if (sym_ok) begin
                            if (!r_neg) begin
                                o_cmd_vld  = 1'b1;
                                o_cmd.kind = rltd_pkg::KIND_SYMBOL;
                                o_cmd.sym  = n_sym[1];
                                o_cmd.cnt  = r_cnt;
                            end
                        end else begin
                            o_cmd_vld  = 1'b1;
                            o_cmd.kind = rltd_pkg::KIND_BAD_SYMBOL;
                            n_drop     = 1'b1;
                        end
                        n_exp_sym = 1'b0;
                        n_flen    = '0;
                        n_cnt     = '0;
                        n_neg     = 1'b0;
                        n_phase   = rltd_pkg::CP_BLANK;
                    end
                end
            end

            // End of message: always report, then start clean.
            if (i_end_of_text) begin
                o_cmd_vld     = 1'b1;
                o_cmd.msg_end = 1'b1;
                n_exp_sym     = 1'b0;
                n_flen        = '0;
                n_cnt         = '0;
                n_neg         = 1'b0;
                n_phase       = rltd_pkg::CP_BLANK;
                n_drop        = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rltd_pkg::CP_BLANK;
            r_exp_sym <= 1'b0;
            r_cnt     <= '0;
            r_neg     <= 1'b0;
            r_flen    <= '0;
            r_drop    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_exp_sym <= n_exp_sym;
            r_cnt     <= n_cnt;
            r_neg     <= n_neg;
            r_flen    <= n_flen;
            r_drop    <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < rltd_pkg::SYM_LEN; i++) begin
            r_sym[i] <= n_sym[i];
        end
    end

endmodule

// File: sv/rltd_cmd_queue.sv
module rltd_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rltd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output rltd_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    localparam int DEPTH = rltd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    rltd_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: sv/rltd_back.sv
module rltd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  rltd_pkg::t_cmd       i_q_cmd,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_kind,
    output logic                 o_run_last,
    output logic                 o_message_end
);

    logic                       r_busy, n_busy;
    logic [rltd_pkg::CNT_W-1:0] r_left, n_left;
    logic [7:0]                 r_sym;
    rltd_pkg::t_kind            r_kind;
    logic                       r_msg_end;
    logic                       last;

    assign last          = (r_left == rltd_pkg::CNT_W'(1));
    assign o_empty       = !r_busy;
    assign o_out_byte    = r_sym;
    assign o_kind        = r_kind;
    assign o_run_last    = last;
    assign o_message_end = last && r_msg_end;

    // Take the next command when idle or when the final result of the run leaves.
    assign o_q_pop = !i_q_empty && (!r_busy || (i_pop && last));

    always_comb begin
        n_busy = r_busy;
        n_left = r_left;
        if (o_q_pop) begin
            n_busy = 1'b1;
            n_left = i_q_cmd.cnt;
        end else if (i_pop && r_busy) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_left = r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_sym     <= i_q_cmd.sym;
            r_kind    <= i_q_cmd.kind;
            r_msg_end <= i_q_cmd.msg_end;
        end
    end

    a_busy_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("active run with zero results left");

    a_report_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_kind != rltd_pkg::KIND_SYMBOL)) |-> last)
        else $error("report result spans more than one entry");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_pop) |=> (r_busy && $stable(r_left) && $stable(r_sym)))
        else $error("stalled result changed");

    a_end_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_kind == rltd_pkg::KIND_END)) |-> o_message_end)
        else $error("end marker without message end");

endmodule

// File: sv/run_length_text_decoder.sv
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ------------------------------------------
// text in   input      push / full          i_text_byte, i_end_of_text
// results   output     empty / pop          o_out_byte, o_kind, o_run_last, o_message_end
//
// One text byte is accepted per cycle while the command queue has room.
// A run of N symbols occupies the expansion side for N results (one result per cycle while pop is high),
// so full rises once the queue backs up behind a long run.
// Reset is synchronous, active low; the queue and the result register come up empty.
// Either side may stall at any time; the queue lets parsing run ahead of expansion.
module run_length_text_decoder #(
    parameter int MAX_RUN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_run_last,
    output logic       o_message_end
);

    logic           in_acc;
    logic           cmd_vld;
    rltd_pkg::t_cmd cmd;
    logic           q_empty;
    logic           q_pop;
    rltd_pkg::t_cmd q_cmd;

    // Accept a request only when the queue can hold whatever command it makes.
    assign in_acc = push && !full;

    // Parse: track the count and symbol fields, emit at most one command per byte.
    rltd_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (in_acc),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_cmd_vld     (cmd_vld),
        .o_cmd         (cmd)
    );

    // Buffer commands so parsing and expansion stall independently.
    rltd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_vld),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    // Expand: repeat each symbol command, mark the last result of each command.
    rltd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

endmodule

// File: bench/run_length_text_decoder_tb.sv
module run_length_text_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT    = 64;
    localparam int TEXT_BYTES   = 270;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    // One decoded result as the block should present it.
    typedef struct packed {
        logic [7:0]      sym;
        rltd_pkg::t_kind kind;
        logic            run_last;
        logic            msg_end;
    } t_result;

    // One text request; drain_first holds it back until every result is out.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         drain_first;
    } t_text_req;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_text_byte;
    logic       i_end_of_text;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic       o_run_last;
    logic       o_message_end;

    run_length_text_decoder #(
        .MAX_RUN(RUN_LIMIT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

    // Text requests waiting to be driven, and results waiting to come out.
    t_text_req pending_text[$];
    t_result   expected_out[$];

    // Message under construction; the last byte gets the end marker.
    logic [7:0] msg_buf[$];
    bit         drain_next;

    int fail_count;
    int cycle_count;

    // Handshake bookkeeping for the monitor, driver and receiver.
    logic req_taken;
    bit   in_flight;
    int   burst_left;
    int   gap_left;
    int   pop_mode;
    int   pop_mode_left;
    int   pop_tick;

    // Parser state of the predictor.
    logic                           in_symbol;
    logic [rltd_pkg::CNT_W-1:0]     run_len;
    logic                           run_neg;
    rltd_pkg::t_count_phase         digit_phase;
    logic [7:0]                     sym_buf[rltd_pkg::SYM_LEN];
    logic [rltd_pkg::FLEN_W-1:0]    sym_len;
    logic                           discarding;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Return every parse field to its idle value (reset and end of message).
    function automatic void clear_parser();
        in_symbol   = 1'b0;
        run_len     = '0;
        run_neg     = 1'b0;
        digit_phase = rltd_pkg::CP_BLANK;
        for (int i = 0; i < rltd_pkg::SYM_LEN; i++) sym_buf[i] = 8'h00;
        sym_len     = '0;
        discarding  = 1'b0;
    endfunction

    // Work out the results one accepted text byte causes and queue them.
    function automatic void decode_text_byte(input logic [7:0] c, input logic eot);
        t_result run_q[$];
        t_result r;
        bit      digit;
        int      v;
        digit = (c >= rltd_pkg::CHAR_ZERO) && (c <= rltd_pkg::CHAR_NINE);
        if (!discarding) begin
            if (c != rltd_pkg::CHAR_COMMA) begin
                if (in_symbol) begin
                    if (sym_len < rltd_pkg::SYM_LEN) sym_buf[sym_len] = c;
                    if (sym_len < rltd_pkg::FLEN_MAX) sym_len = sym_len + 1'b1;
                end else begin
                    // atoi: blanks, optional sign, digits, then ignore the rest
                    case (digit_phase)
                        rltd_pkg::CP_BLANK: begin
                            if (c == rltd_pkg::CHAR_SPACE ||
                                (c >= rltd_pkg::CHAR_TAB && c <= rltd_pkg::CHAR_CR)) begin
                                digit_phase = rltd_pkg::CP_BLANK;
                            end else if (c == rltd_pkg::CHAR_PLUS) begin
                                digit_phase = rltd_pkg::CP_SIGN;
                            end else if (c == rltd_pkg::CHAR_MINUS) begin
                                run_neg     = 1'b1;
                                digit_phase = rltd_pkg::CP_SIGN;
                            end else if (digit) begin
                                run_len     = rltd_pkg::CNT_W'(c - rltd_pkg::CHAR_ZERO);
                                digit_phase = rltd_pkg::CP_DIGITS;
                            end else begin
                                digit_phase = rltd_pkg::CP_DONE;
                            end
                        end
                        rltd_pkg::CP_SIGN: begin
                            if (digit) begin
                                run_len     = rltd_pkg::CNT_W'(c - rltd_pkg::CHAR_ZERO);
                                digit_phase = rltd_pkg::CP_DIGITS;
                            end else begin
                                digit_phase = rltd_pkg::CP_DONE;
                            end
                        end
                        rltd_pkg::CP_DIGITS: begin
                            if (digit) begin
                                v = int'(run_len) * 10 + int'(c - rltd_pkg::CHAR_ZERO);
                                run_len = (v > int'(rltd_pkg::CNT_SAT)) ?
                                          rltd_pkg::CNT_SAT : rltd_pkg::CNT_W'(v);
                            end else begin
                                digit_phase = rltd_pkg::CP_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (c == rltd_pkg::CHAR_COMMA || eot) begin
                if (!in_symbol) begin
                    digit_phase = rltd_pkg::CP_BLANK;
                    if (run_len == 0 || (!run_neg && run_len > RUN_LIMIT)) begin
                        r = '{sym: 8'h00, kind: rltd_pkg::KIND_BAD_COUNT, run_last: 1'b0,
                              msg_end: 1'b0};
                        run_q.push_back(r);
                        discarding = 1'b1;
                    end else begin
                        in_symbol = 1'b1;
                    end
                end else begin
                    if (sym_len == rltd_pkg::SYM_LEN && sym_buf[0] == rltd_pkg::CHAR_QUOTE &&
                        sym_buf[2] == rltd_pkg::CHAR_QUOTE) begin
                        // a negative run checks the field but emits nothing
                        if (!run_neg) begin
                            for (int k = 0; k < run_len && k < RUN_LIMIT; k++) begin
                                r = '{sym: sym_buf[1], kind: rltd_pkg::KIND_SYMBOL,
                                      run_last: 1'b0, msg_end: 1'b0};
                                run_q.push_back(r);
                            end
                        end
                    end else begin
                        r = '{sym: 8'h00, kind: rltd_pkg::KIND_BAD_SYMBOL, run_last: 1'b0,
                              msg_end: 1'b0};
                        run_q.push_back(r);
                        discarding = 1'b1;
                    end
                    in_symbol   = 1'b0;
                    sym_len     = '0;
                    run_len     = '0;
                    run_neg     = 1'b0;
                    digit_phase = rltd_pkg::CP_BLANK;
                end
            end
        end
        if (eot) begin
            // nothing to report at the end still yields a bare end marker
            if (run_q.size() == 0) begin
                r = '{sym: 8'h00, kind: rltd_pkg::KIND_END, run_last: 1'b0, msg_end: 1'b0};
                run_q.push_back(r);
            end
            run_q[run_q.size()-1].msg_end = 1'b1;
            clear_parser();
        end
        if (run_q.size() > 0) run_q[run_q.size()-1].run_last = 1'b1;
        foreach (run_q[i]) expected_out.push_back(run_q[i]);
    endfunction

    // Append characters of a string to the message under construction.
    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
    endtask

    // Move the message into the request queue, end marker on its last byte.
    task automatic flush_message();
        t_text_req q;
        for (int i = 0; i < msg_buf.size(); i++) begin
            q.ch          = msg_buf[i];
            q.eot         = (i == msg_buf.size() - 1);
            q.drain_first = drain_next;
            drain_next    = 1'b0;
            pending_text.push_back(q);
        end
        msg_buf.delete();
    endtask

    // Build one random message: mostly well-formed pairs, some noise.
    task automatic add_random_message();
        int  npairs;
        int  r;
        int  n;
        int  blen;
        if ($urandom_range(0, 9) == 0) begin
            // pure noise, any byte at all
            blen = $urandom_range(1, 6);
            for (int i = 0; i < blen; i++) msg_buf.push_back(8'($urandom_range(0, 255)));
            flush_message();
            return;
        end
        npairs = $urandom_range(1, 4);
        for (int p = 0; p < npairs; p++) begin
            // count field
            if ($urandom_range(0, 7) == 0) begin
                r = $urandom_range(0, 5);
                msg_buf.push_back((r == 5) ? rltd_pkg::CHAR_SPACE :
                                             8'(rltd_pkg::CHAR_TAB + r));
            end
            r = $urandom_range(0, 99);
            if (r < 8) msg_buf.push_back(rltd_pkg::CHAR_MINUS);
            else if (r < 14) msg_buf.push_back(rltd_pkg::CHAR_PLUS);
            r = $urandom_range(0, 99);
            if (r < 80) n = $urandom_range(1, 6);
            else if (r < 91) n = $urandom_range(7, RUN_LIMIT);
            else if (r < 94) n = 0;
            else if (r < 97) n = $urandom_range(RUN_LIMIT + 1, 199);
            else n = $urandom_range(1000, 99999);
            add_str($sformatf("%0d", n));
            if ($urandom_range(0, 19) == 0) add_str("x9");
            msg_buf.push_back(rltd_pkg::CHAR_COMMA);
            // symbol field
            if ($urandom_range(0, 9) != 0) begin
                msg_buf.push_back(rltd_pkg::CHAR_QUOTE);
                msg_buf.push_back(8'($urandom_range(0, 255)));
                msg_buf.push_back(rltd_pkg::CHAR_QUOTE);
            end else begin
                blen = $urandom_range(0, 4);
                for (int i = 0; i < blen; i++) begin
                    r = $urandom_range(0, 3);
                    msg_buf.push_back((r == 0) ? rltd_pkg::CHAR_QUOTE :
                                                 8'($urandom_range(0, 255)));
                end
            end
            // separator; the final pair may carry a trailing comma
            if (p < npairs - 1 || $urandom_range(0, 4) == 0) begin
                msg_buf.push_back(rltd_pkg::CHAR_COMMA);
            end
        end
        flush_message();
    endtask

    // Monitor: check accepted results, predict from accepted requests.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected result sym=%02h kind=%0d last=%0b end=%0b",
                             $time, o_out_byte, o_kind, o_run_last, o_message_end);
                    fail_count++;
                end else begin
                    exp_r = expected_out.pop_front();
                    if (o_out_byte !== exp_r.sym) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, exp_r.sym, o_out_byte);
                        fail_count++;
                    end
                    if (o_kind !== exp_r.kind) begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, exp_r.kind, o_kind);
                        fail_count++;
                    end
                    if (o_run_last !== exp_r.run_last) begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, exp_r.run_last, o_run_last);
                        fail_count++;
                    end
                    if (o_message_end !== exp_r.msg_end) begin
                        $display("%0t: message_end expected %0b actual %0b",
                                 $time, exp_r.msg_end, o_message_end);
                        fail_count++;
                    end
                end
            end
            if (push && !full) decode_text_byte(i_text_byte, i_end_of_text);
            req_taken <= push && !full;
        end
    end

    // Driver: send requests in bursts with random gaps between them.
    always @(negedge i_clk) begin
        t_text_req q;
        if (i_rst_n) begin
            if (in_flight && req_taken) in_flight = 1'b0;
            if (!in_flight) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_text.size() > 0 &&
                             !(pending_text[0].drain_first && expected_out.size() > 0)) begin
                    q = pending_text.pop_front();
                    i_text_byte   <= q.ch;
                    i_end_of_text <= q.eot;
                    push          <= 1'b1;
                    in_flight      = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // a gap of zero keeps long stretches without idling
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    // hold while draining or when out of requests
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a pattern that switches mode every so often.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pop_mode_left == 0) begin
                pop_mode      = $urandom_range(0, 3);
                pop_mode_left = $urandom_range(32, 256);
            end
            pop_mode_left--;
            pop_tick++;
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= (pop_tick % 5 == 0);
                default: pop <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog: end the run if it takes far longer than the slowest correct one.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_text_byte   = 8'h00;
        i_end_of_text = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        in_flight     = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        pop_mode      = 0;
        pop_mode_left = 0;
        pop_tick      = 0;
        drain_next    = 1'b0;
        clear_parser();

        // Directed: extreme symbol bytes, the longest run with a trailing comma,
        // a negative run ending in a bare end marker, saturated oversize count,
        // non-numeric count, short symbol field, zero count then dropped bytes.
        add_str("2,'");
        msg_buf.push_back(8'hFF);
        msg_buf.push_back(rltd_pkg::CHAR_QUOTE);
        flush_message();
        add_str("64,'");
        msg_buf.push_back(8'h00);
        add_str("',");
        flush_message();
        add_str("-9,'z'");
        flush_message();
        add_str("\t 999,");
        flush_message();
        add_str("+x");
        flush_message();
        add_str("1,''");
        flush_message();
        add_str("0,7");
        flush_message();

        // Random part; pause at least once until every result has drained.
        drain_next = 1'b1;
        while (pending_text.size() < TEXT_BYTES) begin
            if (pending_text.size() > 160 && pending_text.size() < 175) drain_next = 1'b1;
            add_random_message();
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_text.size() != 0 || in_flight) @(posedge i_clk);
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
